// ===== rtl/core/gcm_pkg.sv =====
// Shared types and constants for the grid cost map neighbor expander.
package gcm_pkg;

  localparam int unsigned CRD_W     = 5;
  localparam int unsigned OCRD_W    = 7;
  localparam int unsigned CRD_EXT_W = 9;
  localparam int unsigned COST_W    = 16;
  localparam int unsigned STEP_W    = 17;
  localparam int unsigned MCOST_W   = 9;

  // Move costs in Q1.8: one axis, two axes (sqrt 2), three axes (sqrt 3).
  localparam logic [MCOST_W-1:0] MCOST_AXIS1 = 9'd256;
  localparam logic [MCOST_W-1:0] MCOST_AXIS2 = 9'd362;
  localparam logic [MCOST_W-1:0] MCOST_AXIS3 = 9'd443;

  // Offset codes of the expansion counters: low, middle and high mean -1, 0 and +1.
  localparam logic [1:0] OFS_LO  = 2'd0;
  localparam logic [1:0] OFS_MID = 2'd1;
  localparam logic [1:0] OFS_HI  = 2'd2;

  localparam int unsigned CMDQ_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_SET_BLOCKED = 3'd0,
    OP_SET_COST    = 3'd1,
    OP_READ        = 3'd2,
    OP_EXPAND      = 3'd3,
    OP_CLEAR       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_NEIGHBOR = 2'd1,
    KIND_EMPTY    = 2'd2
  } kind_e;

  typedef struct packed {
    op_e               op;
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [CRD_W-1:0]  z;
    logic              in_grid;
    logic              blocked;
    logic [COST_W-1:0] cost;
  } cmd_t;

endpackage

// ===== rtl/core/gcm_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface gcm_in_if import gcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [CRD_W-1:0]  cell_x;
  logic [CRD_W-1:0]  cell_y;
  logic [CRD_W-1:0]  cell_z;
  logic              blocked_in;
  logic [COST_W-1:0] cost_in;

  modport source (
    output valid, opcode, cell_x, cell_y, cell_z, blocked_in, cost_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, cell_x, cell_y, cell_z, blocked_in, cost_in,
    output ready
  );
endinterface

interface gcm_out_if import gcm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [OCRD_W-1:0] out_x;
  logic signed [OCRD_W-1:0] out_y;
  logic signed [OCRD_W-1:0] out_z;
  logic [STEP_W-1:0]        step_cost;
  logic                     blocked_out;
  logic                     last;

  modport source (
    output valid, kind, out_x, out_y, out_z, step_cost, blocked_out, last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_x, out_y, out_z, step_cost, blocked_out, last,
    output ready
  );
endinterface

// ===== rtl/core/gcm_front.sv =====
// Front end: accepts input items, classifies them and drops those with no effect.
module gcm_front import gcm_pkg::*; #(
  parameter int unsigned GRID_SIZE = 32
) (
  gcm_in_if.sink in_i,
  input  logic   init_busy_i,
  input  logic   q_ready_i,
  output logic   q_push_o,
  output cmd_t   q_cmd_o
);

  localparam logic [CRD_EXT_W-1:0] GRID_LIM = CRD_EXT_W'(GRID_SIZE);

  logic in_grid;
  logic keep;
  op_e  op;

  assign op = op_e'(in_i.opcode);

  assign in_grid =
    ({{(CRD_EXT_W-CRD_W){1'b0}}, in_i.cell_x} < GRID_LIM) &&
    ({{(CRD_EXT_W-CRD_W){1'b0}}, in_i.cell_y} < GRID_LIM) &&
    ({{(CRD_EXT_W-CRD_W){1'b0}}, in_i.cell_z} < GRID_LIM);

  always_comb begin
    keep = 1'b0;
    case (op)
      OP_SET_BLOCKED, OP_SET_COST: begin
        keep = in_grid;
      end
      OP_READ, OP_EXPAND, OP_CLEAR: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_i.ready = q_ready_i && !init_busy_i;
  assign q_push_o   = in_i.valid && in_i.ready && keep;

  assign q_cmd_o.op      = op;
  assign q_cmd_o.x       = in_i.cell_x;
  assign q_cmd_o.y       = in_i.cell_y;
  assign q_cmd_o.z       = in_i.cell_z;
  assign q_cmd_o.in_grid = in_grid;
  assign q_cmd_o.blocked = in_i.blocked_in;
  assign q_cmd_o.cost    = in_i.cost_in;

endmodule

// ===== rtl/core/gcm_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
module gcm_cmd_fifo import gcm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

  cmd_t          mem_q [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [PW:0]   cnt_q;

  assign ready_o = (cnt_q != (PW+1)'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/gcm_back.sv =====
// Back end: cell store, clearing sweep, reads and the neighbor expansion sequencer.
module gcm_back import gcm_pkg::*; #(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         q_valid_i,
  input  cmd_t         q_cmd_i,
  output logic         q_pop_o,
  output logic         init_busy_o,
  gcm_out_if.source    out_o
);

  localparam int unsigned CW    = $clog2(GRID_SIZE);
  localparam int unsigned AW    = 3 * CW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam logic [CRD_EXT_W-1:0] GRID_LIM = CRD_EXT_W'(GRID_SIZE);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_EXPAND = 3'd4;

  logic              blk_mem  [DEPTH];
  logic [COST_W-1:0] cost_mem [DEPTH];

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic              diag_q;

  logic [CRD_W-1:0]  cx_q, cy_q, cz_q;
  logic [1:0]        dx_q, dy_q, dz_q;
  logic              seq_done_q;

  logic              rd_valid_q;
  logic [OCRD_W-1:0] rd_x_q, rd_y_q, rd_z_q;
  logic              rd_in_grid_q;
  logic [MCOST_W-1:0] rd_mcost_q;
  logic              blk_rd_q;
  logic [COST_W-1:0] cost_rd_q;

  logic              hold_valid_q;
  logic [OCRD_W-1:0] hold_x_q, hold_y_q, hold_z_q;
  logic [STEP_W-1:0] hold_cost_q;

  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [OCRD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic [STEP_W-1:0] out_cost_q;
  logic              out_blk_q;
  logic              out_last_q;

  logic              out_free;
  logic              pop;
  logic              sweep;
  logic              blk_we, cost_we;
  logic [AW-1:0]     waddr;
  logic              wblk;
  logic [COST_W-1:0] wcost;
  logic              mem_re;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     cmd_addr;
  logic [CRD_EXT_W-1:0] cmd_x_e, cmd_y_e, cmd_z_e;

  logic [OCRD_W-1:0] nx, ny, nz;
  logic [CRD_EXT_W-1:0] nx_e, ny_e, nz_e;
  logic              n_in_grid;
  logic [AW-1:0]     n_addr;
  logic [1:0]        moves;
  logic              pos_ok;
  logic              pos_last;
  logic [MCOST_W-1:0] pos_mcost;

  logic              nbr_ok;
  logic [STEP_W-1:0] nbr_cost;
  logic              need_push;
  logic              consume;
  logic              exp_adv;
  logic              exp_done;

  logic              push;
  kind_e             push_kind;
  logic [OCRD_W-1:0] push_x, push_y, push_z;
  logic [STEP_W-1:0] push_cost;
  logic              push_blk;
  logic              push_last;

  // Address of the queued command's cell.
  assign cmd_x_e  = {{(CRD_EXT_W-CRD_W){1'b0}}, q_cmd_i.x};
  assign cmd_y_e  = {{(CRD_EXT_W-CRD_W){1'b0}}, q_cmd_i.y};
  assign cmd_z_e  = {{(CRD_EXT_W-CRD_W){1'b0}}, q_cmd_i.z};
  assign cmd_addr = {cmd_z_e[CW-1:0], cmd_y_e[CW-1:0], cmd_x_e[CW-1:0]};

  // Neighbor at the current offset of the expansion counters.
  assign nx = {{(OCRD_W-CRD_W){1'b0}}, cx_q} + {{(OCRD_W-2){1'b0}}, dx_q} - OCRD_W'(1);
  assign ny = {{(OCRD_W-CRD_W){1'b0}}, cy_q} + {{(OCRD_W-2){1'b0}}, dy_q} - OCRD_W'(1);
  assign nz = {{(OCRD_W-CRD_W){1'b0}}, cz_q} + {{(OCRD_W-2){1'b0}}, dz_q} - OCRD_W'(1);
  assign nx_e = {{(CRD_EXT_W-OCRD_W){1'b0}}, nx};
  assign ny_e = {{(CRD_EXT_W-OCRD_W){1'b0}}, ny};
  assign nz_e = {{(CRD_EXT_W-OCRD_W){1'b0}}, nz};
  assign n_in_grid = !nx[OCRD_W-1] && (nx_e < GRID_LIM) &&
                     !ny[OCRD_W-1] && (ny_e < GRID_LIM) &&
                     !nz[OCRD_W-1] && (nz_e < GRID_LIM);
  assign n_addr = {nz_e[CW-1:0], ny_e[CW-1:0], nx_e[CW-1:0]};

  assign moves = {1'b0, (dx_q != OFS_MID)} + {1'b0, (dy_q != OFS_MID)} +
                 {1'b0, (dz_q != OFS_MID)};
  assign pos_ok   = (moves != 2'd0) && (diag_q || (moves == 2'd1));
  assign pos_last = (dx_q == OFS_HI) && (dy_q == OFS_HI) && (dz_q == OFS_HI);

  always_comb begin
    case (moves)
      2'd1:    pos_mcost = MCOST_AXIS1;
      2'd2:    pos_mcost = MCOST_AXIS2;
      default: pos_mcost = MCOST_AXIS3;
    endcase
  end

  // A registered neighbor read is evaluated here; it waits while the output is full and a neighbor is held.
  assign out_free  = !out_valid_q || out_o.ready;
  assign nbr_ok    = rd_valid_q && !(rd_in_grid_q && blk_rd_q);
  assign nbr_cost  = STEP_W'(rd_mcost_q) +
                     (rd_in_grid_q ? {{(STEP_W-COST_W){1'b0}}, cost_rd_q} : '0);
  assign need_push = nbr_ok && hold_valid_q;
  assign consume   = rd_valid_q && (!need_push || out_free);
  assign exp_adv   = (state_q == ST_EXPAND) && !seq_done_q && (!rd_valid_q || consume);
  assign exp_done  = (state_q == ST_EXPAND) && seq_done_q && !rd_valid_q && out_free;

  assign pop         = (state_q == ST_IDLE) && q_valid_i;
  assign q_pop_o     = pop;
  assign init_busy_o = (state_q == ST_INIT);
  assign sweep       = (state_q == ST_INIT) || (state_q == ST_CLEAR);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    blk_we    = 1'b0;
    cost_we   = 1'b0;
    mem_re    = 1'b0;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        blk_we    = 1'b1;
        cost_we   = 1'b1;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == {AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          case (q_cmd_i.op)
            OP_SET_BLOCKED: begin
              blk_we = 1'b1;
            end
            OP_SET_COST: begin
              cost_we = 1'b1;
            end
            OP_READ: begin
              mem_re  = q_cmd_i.in_grid;
              state_d = ST_READ;
            end
            OP_EXPAND: begin
              state_d = ST_EXPAND;
            end
            OP_CLEAR: begin
              state_d = ST_CLEAR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EXPAND: begin
        mem_re = exp_adv && pos_ok && n_in_grid;
        if (exp_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign waddr = sweep ? clr_cnt_q : cmd_addr;
  assign wblk  = sweep ? 1'b0 : q_cmd_i.blocked;
  assign wcost = sweep ? '0 : q_cmd_i.cost;
  assign raddr = (state_q == ST_IDLE) ? cmd_addr : n_addr;

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[waddr] <= wblk;
    end
    if (mem_re) begin
      blk_rd_q <= blk_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cost_we) begin
      cost_mem[waddr] <= wcost;
    end
    if (mem_re) begin
      cost_rd_q <= cost_mem[raddr];
    end
  end

  always_comb begin
    push      = 1'b0;
    push_kind = KIND_NEIGHBOR;
    push_x    = hold_x_q;
    push_y    = hold_y_q;
    push_z    = hold_z_q;
    push_cost = hold_cost_q;
    push_blk  = 1'b0;
    push_last = 1'b0;
    if ((state_q == ST_READ) && out_free) begin
      push      = 1'b1;
      push_kind = KIND_READ;
      push_x    = rd_x_q;
      push_y    = rd_y_q;
      push_z    = rd_z_q;
      push_cost = rd_in_grid_q ? {{(STEP_W-COST_W){1'b0}}, cost_rd_q} : '0;
      push_blk  = rd_in_grid_q && blk_rd_q;
      push_last = 1'b1;
    end else if ((state_q == ST_EXPAND) && consume && need_push) begin
      push = 1'b1;
    end else if (exp_done) begin
      push      = 1'b1;
      push_last = 1'b1;
      if (!hold_valid_q) begin
        push_kind = KIND_EMPTY;
        push_x    = {{(OCRD_W-CRD_W){1'b0}}, cx_q};
        push_y    = {{(OCRD_W-CRD_W){1'b0}}, cy_q};
        push_z    = {{(OCRD_W-CRD_W){1'b0}}, cz_q};
        push_cost = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      clr_cnt_q    <= '0;
      diag_q       <= 1'b1;
      seq_done_q   <= 1'b0;
      rd_valid_q   <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      if (cfg_we_i) begin
        diag_q <= cfg_wdata_i;
      end
      if (pop && (q_cmd_i.op == OP_EXPAND)) begin
        seq_done_q <= 1'b0;
      end else if (exp_adv && pos_last) begin
        seq_done_q <= 1'b1;
      end
      if (exp_adv) begin
        rd_valid_q <= pos_ok;
      end else if (consume) begin
        rd_valid_q <= 1'b0;
      end
      if (exp_done) begin
        hold_valid_q <= 1'b0;
      end else if (consume && nbr_ok) begin
        hold_valid_q <= 1'b1;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cx_q         <= q_cmd_i.x;
      cy_q         <= q_cmd_i.y;
      cz_q         <= q_cmd_i.z;
      dx_q         <= OFS_LO;
      dy_q         <= OFS_LO;
      dz_q         <= OFS_LO;
      rd_x_q       <= {{(OCRD_W-CRD_W){1'b0}}, q_cmd_i.x};
      rd_y_q       <= {{(OCRD_W-CRD_W){1'b0}}, q_cmd_i.y};
      rd_z_q       <= {{(OCRD_W-CRD_W){1'b0}}, q_cmd_i.z};
      rd_in_grid_q <= q_cmd_i.in_grid;
    end else if (exp_adv) begin
      rd_x_q       <= nx;
      rd_y_q       <= ny;
      rd_z_q       <= nz;
      rd_in_grid_q <= n_in_grid;
      rd_mcost_q   <= pos_mcost;
      if (dx_q == OFS_HI) begin
        dx_q <= OFS_LO;
        if (dy_q == OFS_HI) begin
          dy_q <= OFS_LO;
          dz_q <= dz_q + 2'd1;
        end else begin
          dy_q <= dy_q + 2'd1;
        end
      end else begin
        dx_q <= dx_q + 2'd1;
      end
    end
    if (consume && nbr_ok) begin
      hold_x_q    <= rd_x_q;
      hold_y_q    <= rd_y_q;
      hold_z_q    <= rd_z_q;
      hold_cost_q <= nbr_cost;
    end
    if (push) begin
      out_kind_q <= push_kind;
      out_x_q    <= push_x;
      out_y_q    <= push_y;
      out_z_q    <= push_z;
      out_cost_q <= push_cost;
      out_blk_q  <= push_blk;
      out_last_q <= push_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.out_x       = signed'(out_x_q);
  assign out_o.out_y       = signed'(out_y_q);
  assign out_o.out_z       = signed'(out_z_q);
  assign out_o.step_cost   = out_cost_q;
  assign out_o.blocked_out = out_blk_q;
  assign out_o.last        = out_last_q;

`ifndef SYNTHESIS
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INIT |-> !out_valid_q)
    else $error("Result item presented during the power-up clearing sweep.");

  a_hold_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> state_q == ST_EXPAND)
    else $error("Held neighbor survived past the end of its expansion.");

  a_read_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> state_q == ST_EXPAND)
    else $error("Neighbor read in flight outside an expansion.");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q != KIND_NEIGHBOR) |-> out_last_q)
    else $error("Read or empty marker item without the last flag.");
`endif

endmodule

// ===== rtl/core/grid_cost_map_neighbor_expander.sv =====
// Top level of the grid cost map neighbor expander.
//
//   Port         Dir  Handshake        Carries
//   in_i         in   valid/ready      opcode, cell coordinates, blocked flag, cost
//   out_o        out  valid/ready      kind, coordinates, step cost, blocked, last
//   cfg_we_i     in   write enable     diagonal_enable in cfg_wdata_i
//
// The front end takes one item per cycle into a two-entry command queue, while the
// queue has room and no sweep after reset runs. The back end takes one command at a
// time; an expansion steps through the neighbor positions one per cycle through the
// single store read port. After reset, and for a clear, the back end sweeps all
// 2**(3*clog2(GRID_SIZE)) cells (32768 at GRID_SIZE 32) one per cycle; in_i is not
// ready during the sweep after reset. A stalled output holds the expansion in place.
module grid_cost_map_neighbor_expander import gcm_pkg::*; #(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gcm_in_if.sink    in_i,
  gcm_out_if.source out_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic init_busy;
  logic q_ready;
  logic q_push;
  cmd_t q_cmd_in;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd_out;

  gcm_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .in_i        (in_i),
    .init_busy_i (init_busy),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in)
  );

  gcm_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  gcm_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd_out),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .out_o       (out_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the grid cost map neighbor expander with its own cell store model.
module tb_top;
  import gcm_pkg::*;

  localparam int unsigned GRID_SIZE      = 32;
  localparam int unsigned GRID_CELLS     = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int          CRD_MAX        = GRID_SIZE - 1;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned PHASE_COUNT    = 5;
  localparam int unsigned PHASE_ITEMS    = 52;
  localparam int unsigned MAX_CLEARS     = 3;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam logic [2:0]  OP_UNUSED_LO   = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI   = 3'd7;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef struct packed {
    logic [2:0]        op;
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [CRD_W-1:0]  z;
    logic              blk;
    logic [COST_W-1:0] cost;
  } cell_cmd_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [OCRD_W-1:0] x;
    logic signed [OCRD_W-1:0] y;
    logic signed [OCRD_W-1:0] z;
    logic [STEP_W-1:0]        cost;
    logic                     blk;
    logic                     last;
  } grid_result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_KNOWN,
    ROW_DIAG
  } row_kind_e;

  typedef struct {
    row_kind_e    kind;
    cell_cmd_t    cmd;
    grid_result_t want;
    logic         diag;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  gcm_in_if  in_if ();
  gcm_out_if out_if ();

  grid_cost_map_neighbor_expander #(
    .GRID_SIZE(GRID_SIZE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [STEP_W-1:0] cell_mem [GRID_CELLS];
  logic              diag_on = 1'b1;
  grid_result_t      awaited_results [$];
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       clears_left = MAX_CLEARS;
  int unsigned       out_stall = 0;
  bit                clear_pending = 1'b0;
  bit                src_calm = 1'b0;
  bit                out_calm = 1'b0;
  int                fx;
  int                fy;
  int                fz;

  function automatic grid_result_t make_result(logic [1:0] kind, int x, int y, int z,
                                               logic [STEP_W-1:0] cost, logic blk, logic last);
    grid_result_t r;
    r.kind = kind;
    r.x    = OCRD_W'(x);
    r.y    = OCRD_W'(y);
    r.z    = OCRD_W'(z);
    r.cost = cost;
    r.blk  = blk;
    r.last = last;
    return r;
  endfunction

  function automatic cell_cmd_t mk_cmd(logic [2:0] op, int x, int y, int z, logic blk,
                                       logic [COST_W-1:0] cost);
    cell_cmd_t c;
    c.op   = op;
    c.x    = CRD_W'(x);
    c.y    = CRD_W'(y);
    c.z    = CRD_W'(z);
    c.blk  = blk;
    c.cost = cost;
    return c;
  endfunction

  function automatic logic [STEP_W-1:0] cell_at(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x > CRD_MAX || y > CRD_MAX || z > CRD_MAX) return '0;
    return cell_mem[{z[CRD_W-1:0], y[CRD_W-1:0], x[CRD_W-1:0]}];
  endfunction

  function automatic void apply_cell_op(cell_cmd_t c);
    logic [3*CRD_W-1:0] addr;
    logic [STEP_W-1:0]  entry;
    logic [MCOST_W-1:0] move_cost;
    grid_result_t       held;
    bit                 have_held;
    int                 moves;
    addr = {c.z, c.y, c.x};
    have_held = 1'b0;
    case (c.op)
      OP_SET_BLOCKED: cell_mem[addr][COST_W] = c.blk;
      OP_SET_COST: cell_mem[addr][COST_W-1:0] = c.cost;
      OP_READ: begin
        entry = cell_mem[addr];
        awaited_results.push_back(make_result(KIND_READ, int'(c.x), int'(c.y), int'(c.z),
                                              STEP_W'(entry[COST_W-1:0]), entry[COST_W], 1'b1));
      end
      OP_EXPAND: begin
        for (int dz = -1; dz <= 1; dz++) begin
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
              moves = int'(dx != 0) + int'(dy != 0) + int'(dz != 0);
              if (moves != 0 && (diag_on || moves == 1)) begin
                entry = cell_at(int'(c.x) + dx, int'(c.y) + dy, int'(c.z) + dz);
                if (!entry[COST_W]) begin
                  move_cost = (moves == 1) ? MCOST_AXIS1 :
                              (moves == 2) ? MCOST_AXIS2 : MCOST_AXIS3;
                  if (have_held) awaited_results.push_back(held);
                  held = make_result(KIND_NEIGHBOR, int'(c.x) + dx, int'(c.y) + dy,
                                     int'(c.z) + dz,
                                     STEP_W'(move_cost) + STEP_W'(entry[COST_W-1:0]),
                                     1'b0, 1'b0);
                  have_held = 1'b1;
                end
              end
            end
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          awaited_results.push_back(held);
        end else begin
          awaited_results.push_back(make_result(KIND_EMPTY, int'(c.x), int'(c.y), int'(c.z),
                                                '0, 1'b0, 1'b1));
        end
      end
      OP_CLEAR: begin
        foreach (cell_mem[i]) cell_mem[i] = '0;
        clear_pending = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(string what, grid_result_t want, grid_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t %s: expected kind %0d at (%0d,%0d,%0d) cost %0d blocked %0b last %0b,",
               $time, what, want.kind, want.x, want.y, want.z, want.cost, want.blk, want.last,
               " got kind %0d at (%0d,%0d,%0d) cost %0d blocked %0b last %0b",
               got.kind, got.x, got.y, got.z, got.cost, got.blk, got.last);
  endfunction

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned source_gap();
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    if (src_calm || $urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  function automatic int edge_biased();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return int'($urandom_range(0, 1));
    if (r < 80) return CRD_MAX - int'($urandom_range(0, 1));
    return int'($urandom_range(0, CRD_MAX));
  endfunction

  function automatic int near_focus(int f);
    int          v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) v = f + int'($urandom_range(0, 4)) - 2;
    else if (r < 85) v = ($urandom_range(0, 1) != 0) ? CRD_MAX : 0;
    else v = int'($urandom_range(0, CRD_MAX));
    if (v < 0) v = 0;
    if (v > CRD_MAX) v = CRD_MAX;
    return v;
  endfunction

  function automatic cell_cmd_t random_cmd();
    cell_cmd_t   c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 24) c.op = OP_SET_BLOCKED;
    else if (r < 42) c.op = OP_SET_COST;
    else if (r < 62) c.op = OP_READ;
    else if (r < 96) c.op = OP_EXPAND;
    else if (r < 97 && clears_left != 0) begin
      c.op = OP_CLEAR;
      clears_left--;
    end else c.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    c.x   = CRD_W'(near_focus(fx));
    c.y   = CRD_W'(near_focus(fy));
    c.z   = CRD_W'(near_focus(fz));
    c.blk = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 9);
    c.cost = (r == 0) ? '0 : (r == 1) ? COST_MAX : COST_W'($urandom);
    return c;
  endfunction

  function automatic dir_row_t item_row(cell_cmd_t c);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.cmd  = c;
    r.want = '0;
    r.diag = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t read_row(int x, int y, int z, logic [COST_W-1:0] cost,
                                        logic blk);
    dir_row_t r;
    r.kind = ROW_KNOWN;
    r.cmd  = mk_cmd(OP_READ, x, y, z, 1'b0, '0);
    r.want = make_result(KIND_READ, x, y, z, STEP_W'(cost), blk, 1'b1);
    r.diag = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t empty_row(int x, int y, int z);
    dir_row_t r;
    r.kind = ROW_KNOWN;
    r.cmd  = mk_cmd(OP_EXPAND, x, y, z, 1'b0, '0);
    r.want = make_result(KIND_EMPTY, x, y, z, '0, 1'b0, 1'b1);
    r.diag = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t diag_row(logic v);
    dir_row_t r;
    r.kind = ROW_DIAG;
    r.cmd  = '0;
    r.want = '0;
    r.diag = v;
    return r;
  endfunction

  task automatic send_cmd(cell_cmd_t c, bit known, grid_result_t want);
    int unsigned gap;
    gap = source_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= c.op;
    in_if.cell_x     <= c.x;
    in_if.cell_y     <= c.y;
    in_if.cell_z     <= c.z;
    in_if.blocked_in <= c.blk;
    in_if.cost_in    <= c.cost;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    if (known) awaited_results.push_back(want);
    else apply_cell_op(c);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (clear_pending ? GRID_CELLS + SETTLE_CYCLES : SETTLE_CYCLES) @(posedge clk_i);
    clear_pending = 1'b0;
  endtask

  task automatic write_diag(logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    diag_on = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic enclose_and_expand(output int unsigned count);
    int          cx;
    int          cy;
    int          cz;
    int          moves;
    int unsigned density;
    cx = near_focus(fx);
    cy = near_focus(fy);
    cz = near_focus(fz);
    density = ($urandom_range(0, 1) != 0) ? 10 : 7;
    count = 0;
    for (int dz = -1; dz <= 1; dz++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          moves = int'(dx != 0) + int'(dy != 0) + int'(dz != 0);
          if (moves != 0 && (diag_on || moves == 1) && $urandom_range(1, 10) <= density &&
              cx + dx >= 0 && cx + dx <= CRD_MAX && cy + dy >= 0 && cy + dy <= CRD_MAX &&
              cz + dz >= 0 && cz + dz <= CRD_MAX) begin
            send_cmd(mk_cmd(OP_SET_BLOCKED, cx + dx, cy + dy, cz + dz, 1'b1,
                            COST_W'($urandom)), 1'b0, '0);
            count++;
          end
        end
      end
    end
    send_cmd(mk_cmd(OP_EXPAND, cx, cy, cz, 1'($urandom_range(0, 1)), COST_W'($urandom)),
             1'b0, '0);
    count++;
  endtask

  initial begin
    grid_result_t got;
    grid_result_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got = make_result(out_if.kind, out_if.out_x, out_if.out_y, out_if.out_z,
                          out_if.step_cost, out_if.blocked_out, out_if.last);
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) report_mismatch("result mismatch", want, got);
        end
      end
      if ($urandom_range(0, 499) == 0) out_calm = !out_calm;
      if (out_stall != 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 2) == 0) out_stall = idle_length();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows [$];
    int unsigned sent;
    int unsigned added;
    cell_cmd_t   c;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= '0;
    in_if.cell_x     <= '0;
    in_if.cell_y     <= '0;
    in_if.cell_z     <= '0;
    in_if.blocked_in <= 1'b0;
    in_if.cost_in    <= '0;
    foreach (cell_mem[i]) cell_mem[i] = '0;

    rows.push_back(read_row(0, 0, 0, '0, 1'b0));
    rows.push_back(read_row(CRD_MAX, CRD_MAX, CRD_MAX, '0, 1'b0));
    rows.push_back(item_row(mk_cmd(OP_SET_COST, CRD_MAX, CRD_MAX, CRD_MAX, 1'b0, COST_MAX)));
    rows.push_back(item_row(mk_cmd(OP_SET_BLOCKED, CRD_MAX, CRD_MAX, CRD_MAX, 1'b1, '0)));
    rows.push_back(read_row(CRD_MAX, CRD_MAX, CRD_MAX, COST_MAX, 1'b1));
    rows.push_back(item_row(mk_cmd(OP_SET_BLOCKED, CRD_MAX, CRD_MAX, CRD_MAX, 1'b0,
                                   16'h1234)));
    rows.push_back(read_row(CRD_MAX, CRD_MAX, CRD_MAX, COST_MAX, 1'b0));
    rows.push_back(item_row(mk_cmd(OP_SET_COST, 0, 0, 0, 1'b1, '0)));
    rows.push_back(item_row(mk_cmd(OP_EXPAND, CRD_MAX - 1, CRD_MAX - 1, CRD_MAX - 1,
                                   1'b0, '0)));
    rows.push_back(item_row(mk_cmd(OP_EXPAND, 0, 0, 0, 1'b1, COST_MAX)));
    rows.push_back(item_row(mk_cmd(OP_EXPAND, CRD_MAX, CRD_MAX, CRD_MAX, 1'b0, '0)));
    rows.push_back(item_row(mk_cmd(OP_UNUSED_LO, CRD_MAX, CRD_MAX, CRD_MAX, 1'b1, '0)));
    rows.push_back(item_row(mk_cmd(OP_UNUSED_HI, CRD_MAX, CRD_MAX, CRD_MAX, 1'b1, '0)));
    rows.push_back(read_row(CRD_MAX, CRD_MAX, CRD_MAX, COST_MAX, 1'b0));
    rows.push_back(diag_row(1'b0));
    rows.push_back(item_row(mk_cmd(OP_SET_BLOCKED, 4, 5, 5, 1'b1, '0)));
    rows.push_back(item_row(mk_cmd(OP_SET_BLOCKED, 6, 5, 5, 1'b1, '0)));
    rows.push_back(item_row(mk_cmd(OP_SET_BLOCKED, 5, 4, 5, 1'b1, '0)));
    rows.push_back(item_row(mk_cmd(OP_SET_BLOCKED, 5, 6, 5, 1'b1, '0)));
    rows.push_back(item_row(mk_cmd(OP_SET_BLOCKED, 5, 5, 4, 1'b1, '0)));
    rows.push_back(item_row(mk_cmd(OP_SET_BLOCKED, 5, 5, 6, 1'b1, '0)));
    rows.push_back(empty_row(5, 5, 5));
    rows.push_back(item_row(mk_cmd(OP_EXPAND, 6, 6, 5, 1'b0, '0)));
    rows.push_back(item_row(mk_cmd(OP_CLEAR, 0, 0, 0, 1'b0, '0)));
    rows.push_back(read_row(CRD_MAX, CRD_MAX, CRD_MAX, '0, 1'b0));
    rows.push_back(item_row(mk_cmd(OP_EXPAND, 5, 5, 5, 1'b0, '0)));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_DIAG: begin
          settle();
          write_diag(rows[i].diag);
        end
        ROW_KNOWN: send_cmd(rows[i].cmd, 1'b1, rows[i].want);
        default: send_cmd(rows[i].cmd, 1'b0, '0);
      endcase
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      write_diag(p % 2 == 0);
      fx = edge_biased();
      fy = edge_biased();
      fz = edge_biased();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 11) == 0) begin
          enclose_and_expand(added);
          sent += added;
        end else begin
          c = random_cmd();
          send_cmd(c, 1'b0, '0);
          if (c.op <= OP_CLEAR) sent++;
        end
      end
    end
    settle();

    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== grid_cost_map_neighbor_expander.f =====
rtl/core/gcm_pkg.sv
rtl/core/gcm_if.sv
rtl/core/gcm_front.sv
rtl/core/gcm_cmd_fifo.sv
rtl/core/gcm_back.sv
rtl/core/grid_cost_map_neighbor_expander.sv
bench/tb_top.sv
